// ===== sv/tvs_pkg.sv =====
// Shared constants, register codes, payload types and the divide-by-five step function
// for the trapezoidal velocity scheduler. No dependencies.
package tvs_pkg;

    localparam int WORD_BITS = 32;
    localparam int DT_BITS   = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_TARGET      = 2'd1;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd2;
    localparam logic [1:0] REG_MAX_ACCEL   = 2'd3;

    localparam logic [30:0] MAX_SPEED_RST  = 31'd327680;
    localparam logic [30:0] MAX_ACCEL_RST  = 31'd6554;

    // Sideband of the travelled-distance root chain
    typedef struct packed {
        logic               far;
        logic signed [20:0] hdiff;
        logic signed [32:0] meas;
        logic [30:0]        up;
        logic [33:0]        dn;
        logic [2:0]         dn_rem;
        logic [30:0]        bd;
    } side_a_t;

    // Sideband of the schedule root chain
    typedef struct packed {
        logic               done;
        logic               brk;
        logic signed [32:0] meas;
        logic [30:0]        up;
        logic [33:0]        dn;
    } side_b_t;

    // One bit of a divide by five: remainder on top, quotient shifts in low
    function automatic logic [36:0] div5_step(input logic [2:0] rem, input logic [33:0] n);
        logic [3:0] r4;
        logic       q;
        logic [2:0] rn;
        r4 = {rem, n[33]};
        q  = (r4 >= 4'd5);
        rn = q ? 3'(r4 - 4'd5) : r4[2:0];
        return {rn, n[32:0], q};
    endfunction

endpackage

// ===== sv/trapezoid_velocity_scheduler_top.sv =====
// Trapezoidal velocity scheduler: odometry sample in, rate command out.
// Depends on tvs_pkg.
//
// One sample may be transferred every cycle while sample_ready is high. Each
// result passes through two 32-stage bit-per-stage square root
// chains (travelled distance, then braking schedule) plus the squaring,
// remaining-distance, radicand, ramp and output register stages. All stages
// advance together and hold while a finished result waits on result_ready.
// The braking distance max_speed^2/(2*max_accel) comes from a bit-serial
// divider that runs after reset and after any write to max_speed
// or max_accel; sample_ready stays low during that run (config writes are
// still taken). A sample with segment_start set latches its own pose, so it
// sees zero travel, and loads the divider result as the braking distance.
// Mode 0 measures Euclidean distance from the start point; mode 1 measures
// heading change for a clockwise turn and mirrors the signs. All rates and
// distances are signed Q16.16, tick_interval is Q0.16 seconds, the command
// saturates to 32 bits, and roots are floored.
module trapezoid_velocity_scheduler_top
    import tvs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic                        segment_start,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [19:0]          heading,
    input  logic signed [31:0]          measured_rate,
    input  logic [15:0]                 tick_interval,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [WORD_BITS-1:0] command,
    output logic                        braking,
    output logic                        segment_done
);

    // ---------------- configuration registers ----------------
    logic               mode_reg;
    logic signed [31:0] target_reg;
    logic [30:0]        max_speed_reg;
    logic [30:0]        max_accel_reg;
    logic [30:0]        accel_eff;

    // ---------------- segment state ----------------
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;
    logic signed [19:0] start_heading_reg;
    logic [30:0]        braking_distance_reg;

    // ---------------- braking distance divider ----------------
    logic        div_start_reg;
    logic        div_busy_reg;
    logic [5:0]  div_cnt_reg;
    logic [61:0] div_num_reg;
    logic [31:0] div_rem_reg;
    logic [31:0] div_den_reg;
    logic [32:0] div_trial;
    logic        div_ge;
    logic [30:0] bd_sat;

    // ---------------- pipeline ----------------
    logic en;
    logic accept;

    logic               s1_valid_reg;
    logic signed [32:0] s1_dx_reg;
    logic signed [32:0] s1_dy_reg;
    logic signed [20:0] s1_hdiff_reg;
    logic signed [32:0] s1_meas_reg;
    logic [15:0]        s1_dt_reg;
    logic [30:0]        s1_bd_reg;

    logic               s2_valid_reg;
    logic [30:0]        s2_ax_reg;
    logic [30:0]        s2_ay_reg;
    logic               s2_far_reg;
    logic [46:0]        s2_prod_reg;
    logic signed [20:0] s2_hdiff_reg;
    logic signed [32:0] s2_meas_reg;
    logic [30:0]        s2_bd_reg;

    logic               s3_valid_reg;
    logic [61:0]        s3_sqx_reg;
    logic [61:0]        s3_sqy_reg;
    logic               s3_far_reg;
    logic [30:0]        s3_up_reg;
    logic [33:0]        s3_dn_reg;
    logic signed [20:0] s3_hdiff_reg;
    logic signed [32:0] s3_meas_reg;
    logic [30:0]        s3_bd_reg;

    logic [32:0] a_valid_reg;
    logic [63:0] a_rem_reg  [0:32];
    logic [31:0] a_root_reg [0:32];
    side_a_t     a_side_reg [0:32];
    logic [63:0] a_rem_next  [0:31];
    logic [31:0] a_root_next [0:31];
    side_a_t     a_side_next [0:31];

    logic               r_valid_reg;
    logic               r_done_reg;
    logic               r_brk_reg;
    logic [30:0]        r_rem_reg;
    side_b_t            r_side_reg;
    logic signed [33:0] remain;
    logic [32:0]        travel;
    logic               rem_done;
    logic               rem_brk;

    logic        p_valid_reg;
    logic [61:0] p_prod_reg;
    side_b_t     p_side_reg;

    logic [32:0] b_valid_reg;
    logic [63:0] b_rem_reg  [0:32];
    logic [31:0] b_root_reg [0:32];
    side_b_t     b_side_reg [0:32];
    logic [63:0] b_rem_next  [0:31];
    logic [31:0] b_root_next [0:31];

    logic               m_valid_reg;
    logic               m_done_reg;
    logic               m_brk_reg;
    logic signed [35:0] m_cmd_reg;
    logic signed [35:0] ramp_cmd;

    logic signed [36:0] out_cmd;

    assign accel_eff = (max_accel_reg == '0) ? 31'd1 : max_accel_reg;

    assign en           = !result_valid || result_ready;
    assign sample_ready = en && !div_busy_reg && !div_start_reg;
    assign accept       = sample_valid && sample_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            target_reg    <= '0;
            max_speed_reg <= MAX_SPEED_RST;
            max_accel_reg <= MAX_ACCEL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[0];
                REG_TARGET:    target_reg    <= cfg_data;
                REG_MAX_SPEED: max_speed_reg <= cfg_data[30:0];
                REG_MAX_ACCEL: max_accel_reg <= cfg_data[30:0];
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    // ---------------- braking distance divider ----------------
    assign div_trial = {div_rem_reg, div_num_reg[61]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};
    assign bd_sat    = (div_num_reg[61:31] != '0) ? 31'h7FFF_FFFF : div_num_reg[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_reg <= 1'b1;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (div_start_reg)
            begin
                div_start_reg <= 1'b0;
                div_busy_reg  <= 1'b1;
                div_cnt_reg   <= 6'd61;
            end
            else if (div_busy_reg)
            begin
                if (div_cnt_reg == '0)
                    div_busy_reg <= 1'b0;
                else
                    div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            if (cfg_write && (cfg_index == REG_MAX_SPEED || cfg_index == REG_MAX_ACCEL))
                div_start_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start_reg)
        begin
            div_num_reg <= max_speed_reg * max_speed_reg;
            div_den_reg <= {accel_eff, 1'b0};
            div_rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_ge ? 32'(div_trial - {1'b0, div_den_reg}) : div_trial[31:0];
            div_num_reg <= {div_num_reg[60:0], div_ge};
        end
    end

    // ---------------- segment state, latched on transfer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg          <= '0;
            start_y_reg          <= '0;
            start_heading_reg    <= '0;
            braking_distance_reg <= '0;
        end
        else if (accept && segment_start)
        begin
            start_x_reg          <= pos_x;
            start_y_reg          <= pos_y;
            start_heading_reg    <= heading;
            braking_distance_reg <= bd_sat;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            a_valid_reg  <= '0;
            r_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            b_valid_reg  <= '0;
            m_valid_reg  <= 1'b0;
            result_valid <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            a_valid_reg  <= {a_valid_reg[31:0], s3_valid_reg};
            r_valid_reg  <= a_valid_reg[32];
            p_valid_reg  <= r_valid_reg;
            b_valid_reg  <= {b_valid_reg[31:0], p_valid_reg};
            m_valid_reg  <= b_valid_reg[32];
            result_valid <= m_valid_reg;
        end
    end

    // ---------------- front stages: deltas, magnitudes, squares, ramp steps ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a starting sample measures from itself
            s1_dx_reg    <= 33'(pos_x) - 33'(segment_start ? pos_x : start_x_reg);
            s1_dy_reg    <= 33'(pos_y) - 33'(segment_start ? pos_y : start_y_reg);
            s1_hdiff_reg <= 21'(heading) - 21'(segment_start ? heading : start_heading_reg);
            s1_meas_reg  <= mode_reg ? -33'(measured_rate) : 33'(measured_rate);
            s1_dt_reg    <= tick_interval;
            s1_bd_reg    <= segment_start ? bd_sat : braking_distance_reg;

            s2_ax_reg    <= s1_dx_reg[32] ? 31'(-s1_dx_reg) : s1_dx_reg[30:0];
            s2_ay_reg    <= s1_dy_reg[32] ? 31'(-s1_dy_reg) : s1_dy_reg[30:0];
            // |d| >= 2^31 saturates the travelled distance
            s2_far_reg   <= (s1_dx_reg[32] ? (s1_dx_reg < -33'sd2147483647)
                                           : s1_dx_reg[31])
                         || (s1_dy_reg[32] ? (s1_dy_reg < -33'sd2147483647)
                                           : s1_dy_reg[31]);
            s2_prod_reg  <= accel_eff * s1_dt_reg;
            s2_hdiff_reg <= s1_hdiff_reg;
            s2_meas_reg  <= s1_meas_reg;
            s2_bd_reg    <= s1_bd_reg;

            s3_sqx_reg   <= s2_ax_reg * s2_ax_reg;
            s3_sqy_reg   <= s2_ay_reg * s2_ay_reg;
            s3_far_reg   <= s2_far_reg;
            s3_up_reg    <= s2_prod_reg[46:DT_BITS];
            // 6*a*dt >> 16, divided by five in the root chain
            s3_dn_reg    <= 34'(({1'b0, s2_prod_reg, 2'b00} + {2'b0, s2_prod_reg, 1'b0})
                                >> DT_BITS);
            s3_hdiff_reg <= s2_hdiff_reg;
            s3_meas_reg  <= s2_meas_reg;
            s3_bd_reg    <= s2_bd_reg;
        end
    end

    // ---------------- distance root chain ----------------
    always_comb
    begin
        logic [63:0] test;
        logic [36:0] d5;
        for (int k = 0; k < 32; k++)
        begin
            test = ({32'b0, a_root_reg[k]} << (32 - k)) | (64'd1 << (2 * (31 - k)));
            a_side_next[k] = a_side_reg[k];
            if (a_rem_reg[k] >= test)
            begin
                a_rem_next[k]  = a_rem_reg[k] - test;
                a_root_next[k] = a_root_reg[k] | (32'd1 << (31 - k));
            end
            else
            begin
                a_rem_next[k]  = a_rem_reg[k];
                a_root_next[k] = a_root_reg[k];
            end
            // two quotient bits per stage for the down step
            if (k < 17)
            begin
                d5 = div5_step(a_side_reg[k].dn_rem, a_side_reg[k].dn);
                d5 = div5_step(d5[36:34], d5[33:0]);
                a_side_next[k].dn_rem = d5[36:34];
                a_side_next[k].dn     = d5[33:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rem_reg[0]         <= s3_far_reg ? 64'd0 : 64'(s3_sqx_reg) + 64'(s3_sqy_reg);
            a_root_reg[0]        <= '0;
            a_side_reg[0].far    <= s3_far_reg;
            a_side_reg[0].hdiff  <= s3_hdiff_reg;
            a_side_reg[0].meas   <= s3_meas_reg;
            a_side_reg[0].up     <= s3_up_reg;
            a_side_reg[0].dn     <= s3_dn_reg;
            a_side_reg[0].dn_rem <= '0;
            a_side_reg[0].bd     <= s3_bd_reg;
            for (int k = 0; k < 32; k++)
            begin
                a_rem_reg[k+1]  <= a_rem_next[k];
                a_root_reg[k+1] <= a_root_next[k];
                a_side_reg[k+1] <= a_side_next[k];
            end
        end
    end

    // ---------------- remaining distance and zone ----------------
    assign travel = a_side_reg[32].far ? (33'd1 << 31) : {1'b0, a_root_reg[32]};

    always_comb
    begin
        if (mode_reg)
            remain = 34'(a_side_reg[32].hdiff) - 34'(target_reg);
        else
            remain = 34'(target_reg) - $signed({1'b0, travel});
        rem_done = (remain <= 34'sd0);
        rem_brk  = !rem_done && (remain <= $signed({3'b0, a_side_reg[32].bd}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_done_reg      <= rem_done;
            r_brk_reg       <= rem_brk;
            r_rem_reg       <= remain[30:0];
            r_side_reg.done <= rem_done;
            r_side_reg.brk  <= rem_brk;
            r_side_reg.meas <= a_side_reg[32].meas;
            r_side_reg.up   <= a_side_reg[32].up;
            r_side_reg.dn   <= a_side_reg[32].dn;

            p_prod_reg <= r_rem_reg * accel_eff;
            p_side_reg <= r_side_reg;
        end
    end

    // ---------------- schedule root chain ----------------
    always_comb
    begin
        logic [63:0] test;
        for (int k = 0; k < 32; k++)
        begin
            test = ({32'b0, b_root_reg[k]} << (32 - k)) | (64'd1 << (2 * (31 - k)));
            if (b_rem_reg[k] >= test)
            begin
                b_rem_next[k]  = b_rem_reg[k] - test;
                b_root_next[k] = b_root_reg[k] | (32'd1 << (31 - k));
            end
            else
            begin
                b_rem_next[k]  = b_rem_reg[k];
                b_root_next[k] = b_root_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // radicand 2*remain*accel, saturated at 2^62
            b_rem_reg[0]  <= (p_prod_reg > (62'd1 << 61)) ? (64'd1 << 62)
                                                           : {1'b0, p_prod_reg, 1'b0};
            b_root_reg[0] <= '0;
            b_side_reg[0] <= p_side_reg;
            for (int k = 0; k < 32; k++)
            begin
                b_rem_reg[k+1]  <= b_rem_next[k];
                b_root_reg[k+1] <= b_root_next[k];
                b_side_reg[k+1] <= b_side_reg[k];
            end
        end
    end

    // ---------------- ramp toward the schedule ----------------
    always_comb
    begin
        logic signed [35:0] sched;
        logic signed [35:0] meas;
        logic signed [35:0] t_up;
        logic signed [35:0] t_dn;
        if (b_side_reg[32].done)
            sched = '0;
        else if (b_side_reg[32].brk)
            sched = $signed({4'b0, b_root_reg[32]});
        else
            sched = $signed({5'b0, max_speed_reg});
        meas = 36'(b_side_reg[32].meas);
        t_up = meas + $signed({5'b0, b_side_reg[32].up});
        t_dn = meas - $signed({2'b0, b_side_reg[32].dn});
        if (meas < sched)
            ramp_cmd = (t_up < sched) ? t_up : sched;
        else if (meas > sched)
            ramp_cmd = (t_dn > sched) ? t_dn : sched;
        else
            ramp_cmd = sched;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_done_reg <= b_side_reg[32].done;
            m_brk_reg  <= b_side_reg[32].brk;
            m_cmd_reg  <= b_side_reg[32].done ? 36'sd0 : ramp_cmd;
        end
    end

    // ---------------- output register: mirror and saturate ----------------
    assign out_cmd = mode_reg ? -37'(m_cmd_reg) : 37'(m_cmd_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_cmd > 37'((64'sd1 <<< (WORD_BITS - 1)) - 1))
                command <= {1'b0, {(WORD_BITS-1){1'b1}}};
            else if (out_cmd < -37'(64'sd1 <<< (WORD_BITS - 1)))
                command <= {1'b1, {(WORD_BITS-1){1'b0}}};
            else
                command <= out_cmd[WORD_BITS-1:0];
            braking      <= m_brk_reg;
            segment_done <= m_done_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_transfer_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |-> (!div_busy_reg && !div_start_reg))
        else $error("sample transferred while braking distance is being computed");

    a_done_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && segment_done) |-> (command == '0 && !braking))
        else $error("finished segment gave nonzero command or braking");

    a_zone_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && r_done_reg) |-> !r_brk_reg)
        else $error("done and braking both set");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_busy_reg) |-> $past(div_start_reg))
        else $error("divider started without request");
`endif

endmodule

// ===== sim/tvs_checker.sv =====
`timescale 1ns / 100ps
// Checker for the trapezoidal velocity scheduler: tracks the register writes,
// predicts one command per sample transfer and compares result transfers.
// Depends on tvs_pkg.
module tvs_checker
    import tvs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               sample_valid,
    input  logic               sample_ready,
    input  logic               segment_start,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [19:0] heading,
    input  logic signed [31:0] measured_rate,
    input  logic [15:0]        tick_interval,
    input  logic               result_valid,
    input  logic               result_ready,
    input  logic signed [31:0] command,
    input  logic               braking,
    input  logic               segment_done,
    output int                 errors,
    output int                 pending,
    output int                 n_results,
    output int                 n_braking,
    output int                 n_done
);

    typedef struct {
        logic signed [31:0] command;
        logic               braking;
        logic               segment_done;
    } rate_cmd_t;

    rate_cmd_t cmd_queue[$];

    // register shadow
    logic        turn_mode;
    longint      goal;
    longint      speed_lim;
    longint      accel_lim;
    // latched segment state
    longint      seg_x, seg_y, seg_hd, brake_dist;

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // forward-move schedule and ramp
    function automatic longint ramp_cmd(longint remain, longint meas, longint unsigned dt,
                                        output logic brk, output logic done);
        longint unsigned ma, p, lim;
        longint sched, up, down, t, cmd;
        ma   = (accel_lim == 0) ? 1 : longint'(accel_lim);
        up   = longint'((ma * dt) >> 16);
        down = longint'((ma * dt * 6) / (64'd5 << 16));
        lim  = 64'd1 << 62;
        brk  = 1'b0;
        done = 1'b0;
        if (remain <= 0)
        begin
            done  = 1'b1;
            sched = 0;
        end
        else if (remain <= brake_dist)
        begin
            brk = 1'b1;
            if (longint'(remain) > lim / (2 * ma)) p = lim;
            else p = 2 * longint'(remain) * ma;
            sched = longint'(floor_root(p));
        end
        else
            sched = speed_lim;
        if (meas < sched)
        begin
            t   = meas + up;
            cmd = (t < sched) ? t : sched;
        end
        else if (meas > sched)
        begin
            t   = meas - down;
            cmd = (t > sched) ? t : sched;
        end
        else
            cmd = sched;
        if (done) cmd = 0;
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rate_cmd_t       want, got;
        longint          dx, dy, travel, remain, cmd;
        longint unsigned ax, ay, bd, ma;
        logic            brk, done;
        if (!rst_n)
        begin
            turn_mode  <= 1'b0;
            goal       <= 0;
            speed_lim  <= 327680;
            accel_lim  <= 6554;
            seg_x      = 0;
            seg_y      = 0;
            seg_hd     = 0;
            brake_dist = 0;
            cmd_queue.delete();
            errors    <= 0;
            n_results <= 0;
            n_braking <= 0;
            n_done    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:      turn_mode <= cfg_data[0];
                    REG_TARGET:    goal      <= longint'($signed(cfg_data));
                    REG_MAX_SPEED: speed_lim <= longint'(cfg_data[30:0]);
                    REG_MAX_ACCEL: accel_lim <= longint'(cfg_data[30:0]);
                    default: ;
                endcase
            end

            if (sample_valid && sample_ready)
            begin
                if (segment_start)
                begin
                    ma = (accel_lim == 0) ? 1 : longint'(accel_lim);
                    bd = (longint'(speed_lim) * longint'(speed_lim)) / (2 * ma);
                    seg_x  = pos_x;
                    seg_y  = pos_y;
                    seg_hd = heading;
                    brake_dist = (bd > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(bd);
                end
                if (!turn_mode)
                begin
                    dx = longint'(pos_x) - seg_x;
                    dy = longint'(pos_y) - seg_y;
                    ax = (dx < 0) ? -dx : dx;
                    ay = (dy < 0) ? -dy : dy;
                    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) travel = 64'h8000_0000;
                    else travel = longint'(floor_root(ax * ax + ay * ay));
                    cmd = ramp_cmd(goal - travel, measured_rate, tick_interval, brk, done);
                end
                else
                begin
                    remain = (longint'(heading) - seg_hd) - goal;
                    cmd = -ramp_cmd(remain, -longint'(measured_rate), tick_interval, brk, done);
                end
                if (cmd > 64'sh7FFF_FFFF) cmd = 64'sh7FFF_FFFF;
                if (cmd < -64'sh8000_0000) cmd = -64'sh8000_0000;
                want.command      = cmd[31:0];
                want.braking      = brk;
                want.segment_done = done;
                cmd_queue.push_back(want);
            end

            if (result_valid && result_ready)
            begin
                got.command      = command;
                got.braking      = braking;
                got.segment_done = segment_done;
                n_results <= n_results + 1;
                n_braking <= n_braking + braking;
                n_done    <= n_done + segment_done;
                if (cmd_queue.size() == 0)
                begin
                    if (errors < 10)
                        $display("ERROR: unexpected result cmd=%0d brk=%0b done=%0b",
                                 command, braking, segment_done);
                    errors <= errors + 1;
                end
                else
                begin
                    want = cmd_queue.pop_front();
                    if (want != got)
                    begin
                        if (errors < 10)
                            $display("ERROR: exp cmd=%0d brk=%0b done=%0b, got %0d %0b %0b",
                                     want.command, want.braking, want.segment_done,
                                     got.command, got.braking, got.segment_done);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= cmd_queue.size();
    end

endmodule

// ===== sim/tb_trapezoid_velocity_scheduler_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the trapezoidal velocity scheduler: clock, reset, samples,
// register phases and verdict. Depends on tvs_pkg, tvs_checker and the scheduler top.
module tb_trapezoid_velocity_scheduler_top;
    import tvs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HEAD_MAX    = 411775;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               sample_valid;
    logic               sample_ready;
    logic               segment_start;
    logic signed [31:0] pos_x, pos_y, measured_rate;
    logic signed [19:0] heading;
    logic [15:0]        tick_interval;
    logic               result_valid;
    logic               result_ready;
    logic signed [31:0] command;
    logic               braking;
    logic               segment_done;

    int errors, pending, n_results, n_braking, n_done;
    int idle_pct, stall_pct, cycles, n_segments;

    trapezoid_velocity_scheduler_top uut (.*);

    tvs_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: random stalls on result_ready
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_trapezoid_velocity_scheduler_top failed");
            $finish;
        end
    end

    // one sample transfer; valid stays high into the next call unless it idles
    task automatic send(input logic seg, input logic [31:0] x, input logic [31:0] y,
                        input logic [19:0] hd, input logic [31:0] v, input logic [15:0] dt);
        if ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        sample_valid  <= 1'b1;
        segment_start <= seg;
        pos_x         <= x;
        pos_y         <= y;
        heading       <= hd;
        measured_rate <= v;
        tick_interval <= dt;
        n_segments    += seg;
        do @(posedge clk); while (!sample_ready);
    endtask

    // stop sending and wait for every outstanding result plus pipeline slack
    task automatic drain();
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (80) @(posedge clk);
    endtask

    // block is idle here; one register per cycle
    task automatic set_regs(input logic m, input logic [31:0] tgt,
                            input logic [31:0] spd, input logic [31:0] acc);
        logic [31:0] vals[4];
        vals = '{{31'd0, m}, tgt, spd, acc};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [19:0] clamp_hd(longint h);
        if (h > HEAD_MAX) h = HEAD_MAX;
        if (h < -HEAD_MAX) h = -HEAD_MAX;
        return h[19:0];
    endfunction

    // random segment: start sample, then samples scattered around the goal, 15% fully random
    task automatic run_segment(input logic m, input longint tgt, input int len);
        longint sx, sy, d;
        logic [19:0] sh;
        sx = $signed($urandom());
        sy = $signed($urandom());
        sh = clamp_hd(longint'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX);
        send(1'b1, sx, sy, sh, $urandom_range(65536), $urandom());
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 15)
                send($urandom_range(1), $urandom(), $urandom(),
                     clamp_hd(longint'($urandom_range(2 * HEAD_MAX)) - HEAD_MAX),
                     $urandom(), $urandom());
            else if (!m)
            begin
                d = (tgt < 0 ? -tgt : tgt) * $urandom_range(120) / 100;
                send(1'b0, sx + d, sy + $signed($urandom_range(8192)) - 4096, sh,
                     longint'($urandom_range(2 * 400000)) - 400000, $urandom());
            end
            else
            begin
                d = tgt * $urandom_range(120) / 100;
                send(1'b0, $urandom(), $urandom(), clamp_hd(longint'($signed(sh)) + d),
                     longint'($urandom_range(2 * 400000)) - 400000, $urandom());
            end
        end
    endtask

    initial
    begin
        logic m;
        longint tgt;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_MODE;
        cfg_data      <= '0;
        sample_valid  <= 1'b0;
        segment_start <= 1'b0;
        pos_x         <= '0;
        pos_y         <= '0;
        heading       <= '0;
        measured_rate <= '0;
        tick_interval <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        n_segments    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 10.0 m goal, 5.0 m/s, 1.0 m/s^2 so the whole segment brakes
        set_regs(1'b0, 32'd655360, 32'd327680, 32'd65536);
        send(1'b1, 32'd0, 32'd0, 20'd0, 32'd0, 16'hFFFF);          // start, zero travel
        send(1'b0, 32'd65536, 32'd0, 20'd0, 32'h7FFF_FFFF, 16'hFFFF); // huge rate, ramps down
        send(1'b0, 32'd131072, 32'd131072, 20'd0, 32'h8000_0000, 16'hFFFF);
        send(1'b0, 32'd655360, 32'd0, 20'd0, 32'd1000, 16'd0);     // exactly at goal
        send(1'b0, 32'd0, 32'd700000, 20'd0, 32'd5000, 16'd100);   // overshoot
        send(1'b0, 32'h8000_0000, 32'd0, 20'd0, 32'd0, 16'd1000);  // far travel x
        send(1'b0, 32'd0, 32'h7FFF_FFFF, 20'd0, 32'd0, 16'd1000);  // large y
        send(1'b0, 32'hFFFF_0000, 32'hFFFF_0000, 20'd0, 32'd0, 16'd1);
        drain();
        // speed and accel extremes, zero accel treated as one, negative goal
        set_regs(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 20'h80000, 32'd0, 16'hFFFF);
        send(1'b0, 32'd0, 32'd0, 20'h7FFFF, 32'h7FFF_0000, 16'hFFFF);
        drain();
        set_regs(1'b0, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
        send(1'b1, 32'd5, 32'd5, 20'd0, 32'd12345, 16'd5000);
        send(1'b0, 32'd0, 32'd0, 20'd0, 32'hFFFF_0000, 16'hFFFF);
        drain();
        // clockwise turn, then a non-negative target that finishes at once
        set_regs(1'b1, -32'sd102944, 32'd65536, 32'd16384);
        send(1'b1, 32'd0, 32'd0, -20'sd200000, -32'sd30000, 16'd6554);
        send(1'b0, 32'd0, 32'd0, -20'sd250000, -32'sd70000, 16'd6554);
        send(1'b0, 32'd0, 32'd0, -20'sd302944, -32'sd5000, 16'd6554);
        send(1'b0, 32'd0, 32'd0, 20'sd411775, 32'sd5000, 16'd6554);
        drain();
        set_regs(1'b1, 32'd0, 32'd65536, 32'd16384);
        send(1'b1, 32'd0, 32'd0, -20'sd411775, 32'sd1, 16'hFFFF);
        send(1'b0, 32'd0, 32'd0, 20'sd0, -32'sd1, 16'hFFFF);
        drain();

        // random phases, rotating through idle and stall patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            m = ph[0] ^ ph[2];
            if (!m)
                tgt = $urandom_range(20 * 65536, 65536);
            else
                tgt = -longint'($urandom_range(300000, 20000));
            set_regs(m, tgt[31:0], $urandom_range(400000, 20000),
                     $urandom_range(131072, 2000));
            for (int s = 0; s < 4; s++)
            begin
                run_segment(m, tgt, 18);
                // sender holds off until every command has come back
                if (ph == 2 && s == 1)
                begin
                    sample_valid <= 1'b0;
                    do @(posedge clk); while (pending != 0);
                end
            end
            drain();
        end

        $display("Covered %0d commands over %0d segment starts: %0d braking, %0d done.",
                 n_results, n_segments, n_braking, n_done);
        if (errors == 0)
            $display("tb_trapezoid_velocity_scheduler_top passed");
        else
            $display("tb_trapezoid_velocity_scheduler_top failed");
        $finish;
    end

endmodule
